@@ rtl/sfr_pkg.sv @@
// Shared types and constants for the sync frame receiver.
`timescale 1ns / 1ps
package sfr_pkg;

    localparam logic [7:0] SYNC_RESET  = 8'h24;
    localparam int         PAYLOAD_LEN = 8;
    localparam logic [3:0] SUM_BYTES   = 4'd9;
    localparam int         ADDR_W      = 3;

    // Register word indexes on the configuration port
    localparam logic REG_SYNC_BYTE = 1'b0;

    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_SYNC     = 3'd1,
        ST_STORED   = 3'd2,
        ST_GOOD     = 3'd3,
        ST_BAD      = 3'd4,
        ST_LOCKED   = 3'd5,
        ST_ERROR    = 3'd6,
        ST_RELEASED = 3'd7
    } status_t;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        status_t                      status;
        byte_t [PAYLOAD_LEN-1:0]      data;
        byte_t                        checksum_byte;
        logic                         buffer_locked;
    } result_t;

endpackage

@@ rtl/sfr_in_if.sv @@
// Input channel: received byte or release command.
`timescale 1ns / 1ps
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;
    logic       rx_error;

    modport source (output valid, output cmd, output rx_byte, output rx_error, input ready);
    modport sink   (input valid, input cmd, input rx_byte, input rx_error, output ready);
endinterface

@@ rtl/sfr_out_if.sv @@
// Result channel: status, frame payload and lock flag.
`timescale 1ns / 1ps
interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] data_byte_1;
    logic [7:0] data_byte_2;
    logic [7:0] data_byte_3;
    logic [7:0] data_byte_4;
    logic [7:0] data_byte_5;
    logic [7:0] data_byte_6;
    logic [7:0] data_byte_7;
    logic [7:0] data_byte_8;
    logic [7:0] checksum_byte;
    logic       buffer_locked;

    modport source (
        output valid, output status,
        output data_byte_1, output data_byte_2, output data_byte_3, output data_byte_4,
        output data_byte_5, output data_byte_6, output data_byte_7, output data_byte_8,
        output checksum_byte, output buffer_locked,
        input ready
    );
    modport sink (
        input valid, input status,
        input data_byte_1, input data_byte_2, input data_byte_3, input data_byte_4,
        input data_byte_5, input data_byte_6, input data_byte_7, input data_byte_8,
        input checksum_byte, input buffer_locked,
        output ready
    );
endinterface

@@ rtl/sfr_apb_cfg.sv @@
// APB register block holding the sync byte.
`timescale 1ns / 1ps
module sfr_apb_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [7:0]                 sync_byte
);
    import sfr_pkg::*;

    logic [7:0] sync_reg;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
        end
        else if (wr_en && (reg_idx == REG_SYNC_BYTE))
        begin
            sync_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (reg_idx == REG_SYNC_BYTE)
        begin
            prdata = {24'd0, sync_reg};
        end
    end

    assign sync_byte = sync_reg;
endmodule

@@ rtl/sfr_frame_ctrl.sv @@
// Frame hunting, payload capture and checksum check, one byte per transfer.
`timescale 1ns / 1ps
module sfr_frame_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             cmd,
    input  logic [7:0]       rx_byte,
    input  logic             rx_error,
    input  logic [7:0]       sync_byte,
    output sfr_pkg::result_t result
);
    import sfr_pkg::*;

    logic                    in_frame_reg, in_frame_next;
    logic [3:0]              byte_count_reg, byte_count_next;
    logic [7:0]              sum_reg, sum_next;
    logic                    locked_reg, locked_next;
    byte_t [PAYLOAD_LEN-1:0] payload_reg;
    logic                    store_en;
    logic [3:0]              count_m1;
    logic [2:0]              store_idx;

    assign count_m1  = byte_count_reg - 4'd1;
    assign store_idx = count_m1[2:0];

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        locked_next     = locked_reg;
        store_en        = 1'b0;
        result.status        = ST_IGNORED;
        result.data          = '0;
        result.checksum_byte = 8'd0;

        priority if (cmd)
        begin
            locked_next   = 1'b0;
            result.status = ST_RELEASED;
        end
        else if (rx_error)
        begin
            result.status = ST_ERROR;
        end
        else if (locked_reg)
        begin
            result.status = ST_LOCKED;
        end
        else if (!in_frame_reg)
        begin
            if (rx_byte == sync_byte)
            begin
                in_frame_next   = 1'b1;
                byte_count_next = 4'd1;
                sum_next        = rx_byte;
                result.status   = ST_SYNC;
            end
        end
        else if (byte_count_reg < SUM_BYTES)
        begin
            // payload byte: store and fold into the running sum
            store_en        = 1'b1;
            sum_next        = sum_reg + rx_byte;
            byte_count_next = byte_count_reg + 4'd1;
            result.status   = ST_STORED;
        end
        else
        begin
            // checksum byte closes the frame either way
            if (sum_reg == rx_byte)
            begin
                locked_next          = 1'b1;
                result.status        = ST_GOOD;
                result.data          = payload_reg;
                result.checksum_byte = rx_byte;
            end
            else
            begin
                result.status = ST_BAD;
            end
            in_frame_next   = 1'b0;
            byte_count_next = 4'd0;
            sum_next        = 8'd0;
        end
        result.buffer_locked = locked_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            byte_count_reg <= 4'd0;
            sum_reg        <= 8'd0;
            locked_reg     <= 1'b0;
        end
        else if (accept)
        begin
            in_frame_reg   <= in_frame_next;
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            locked_reg     <= locked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_en)
        begin
            payload_reg[store_idx] <= rx_byte;
        end
    end
endmodule

@@ rtl/sync_frame_receiver_sum8_unit.sv @@
// Top level of the sync byte frame receiver with 8-bit sum check.
`timescale 1ns / 1ps
// Each result is registered and appears in the cycle after its input transfer.
// Throughput: one byte or command per cycle if res_out is ready; the result
//   register frees in the cycle it is taken, so both sides run together.
// Reset (rst_n, async low): hunting, unlocked, count and sum cleared, sync
//   byte back to 0x24, result register empty. The payload store is not reset.
module sync_frame_receiver_sum8_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    sfr_in_if.sink                     rx_in,
    sfr_out_if.source                  res_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import sfr_pkg::*;

    logic [7:0] sync_val;
    logic       accept;
    logic       out_valid_reg;
    result_t    result;
    result_t    res_reg;

    // Configuration registers
    sfr_apb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sync_byte (sync_val)
    );

    // Take a new item whenever the result register is empty or being drained
    assign rx_in.ready = !out_valid_reg || res_out.ready;
    assign accept      = rx_in.valid && rx_in.ready;

    // Frame state machine and combinational result
    sfr_frame_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (rx_in.cmd),
        .rx_byte   (rx_in.rx_byte),
        .rx_error  (rx_in.rx_error),
        .sync_byte (sync_val),
        .result    (result)
    );

    // Result register: load on each input transfer, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= result;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.status        = res_reg.status;
    assign res_out.data_byte_1   = res_reg.data[0];
    assign res_out.data_byte_2   = res_reg.data[1];
    assign res_out.data_byte_3   = res_reg.data[2];
    assign res_out.data_byte_4   = res_reg.data[3];
    assign res_out.data_byte_5   = res_reg.data[4];
    assign res_out.data_byte_6   = res_reg.data[5];
    assign res_out.data_byte_7   = res_reg.data[6];
    assign res_out.data_byte_8   = res_reg.data[7];
    assign res_out.checksum_byte = res_reg.checksum_byte;
    assign res_out.buffer_locked = res_reg.buffer_locked;
endmodule

@@ rtl/sfr_checker.sv @@
// Port-level assertions for the frame receiver, bound to the top level.
`timescale 1ns / 1ps
module sfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [7:0] data_byte_1,
    input logic [7:0] data_byte_8,
    input logic [7:0] checksum_byte,
    input logic       buffer_locked
);
    import sfr_pkg::*;

    // A pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

    // An empty result register never blocks the input side
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // A good frame always reports the buffer as locked, a release never does
    a_lock_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != ST_GOOD || buffer_locked)
                      && (status != ST_RELEASED || !buffer_locked))
        else $error("lock flag disagrees with status");

    // Payload fields are zero on every result but a good frame
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_GOOD |->
            data_byte_1 == 8'd0 && data_byte_8 == 8'd0 && checksum_byte == 8'd0)
        else $error("payload leaked on non-good status");
endmodule

bind sync_frame_receiver_sum8_unit sfr_checker u_sfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (rx_in.ready),
    .out_valid     (res_out.valid),
    .out_ready     (res_out.ready),
    .status        (res_out.status),
    .data_byte_1   (res_out.data_byte_1),
    .data_byte_8   (res_out.data_byte_8),
    .checksum_byte (res_out.checksum_byte),
    .buffer_locked (res_out.buffer_locked)
);
